// ----- sv/point_plane_residual_jacobian_assert.svh -----
// Assertion macros for the point-plane residual block.
`ifndef POINT_PLANE_RESIDUAL_JACOBIAN_ASSERT_SVH
`define POINT_PLANE_RESIDUAL_JACOBIAN_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define PPRJ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define PPRJ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- sv/pprj_pkg.sv -----
// Package with payload types, register codes and fixed-point helpers.
package pprj_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int PW        = 82;

	localparam logic [31:0] GAIN_RESET = 32'h0100_0000;
	localparam logic [31:0] QUAT_W_RESET = 32'h4000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN    = 3'd0,
		REG_TRANS_X = 3'd1,
		REG_TRANS_Y = 3'd2,
		REG_TRANS_Z = 3'd3,
		REG_QUAT_W  = 3'd4,
		REG_QUAT_X  = 3'd5,
		REG_QUAT_Y  = 3'd6,
		REG_QUAT_Z  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic signed [31:0] plane_offset;
		logic        [31:0] point_weight;
	} point_t;

	typedef struct packed {
		logic signed [31:0] residual;
		logic signed [31:0] jac_trans_x;
		logic signed [31:0] jac_trans_y;
		logic signed [31:0] jac_trans_z;
		logic signed [31:0] jac_rot_x;
		logic signed [31:0] jac_rot_y;
		logic signed [31:0] jac_rot_z;
	} result_t;

	// Divide by 2^sh, rounding to nearest with ties away from zero.
	function automatic logic signed [PW-1:0] rnd_sh(input logic signed [PW-1:0] p,
			input int unsigned sh);
		logic signed [PW-1:0] mag;
		logic        [PW-1:0] half;
		logic signed [PW-1:0] q;
		mag  = p[PW-1] ? -p : p;
		half = PW'(1) << (sh - 1);
		q    = $signed((PW'(mag) + half) >> sh);
		return p[PW-1] ? -q : q;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
		if (v > PW'(64'sh7FFF_FFFF))
			return 32'sh7FFF_FFFF;
		else if (v < -PW'(64'sh8000_0000))
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

endpackage

// ----- sv/point_plane_residual_jacobian.sv -----
// Point-to-plane residual and Jacobian pipeline: top level.
//
// Each transfer on the point channel carries one sensor point, its plane
// normal, the plane offset and a weight. For each point the block delivers
// one transfer on the result channel: the scaled residual, the translation
// Jacobian and the rotation Jacobian, all Q16.16 and saturated.
// The pose and information gain sit in eight registers written through the
// cfg_we / cfg_index / cfg_data port; the user must change them only while
// the block holds no point in flight, which the block itself does not enforce.
// The datapath is an eight-stage pipeline: quaternion products, rotation
// matrix, rotation products, sums, plane and cross products, sums, split
// scale products, and a final rounding and saturation stage whose register
// drives the result channel. A new point is taken every cycle unless a held
// result stalls the pipeline.
// When result_stall is high while a result waits, the whole pipeline holds
// and point_stall goes high in the same cycle; nothing is dropped.
// Reset empties the pipeline and loads the identity pose with unit gain.
module point_plane_residual_jacobian
	import pprj_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 point_valid,
	output logic                 point_stall,
	input  point_t               point_data,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result_data
);

	localparam int QP_W  = 35;
	localparam int R_W   = 36;
	localparam int RP_W  = 37;
	localparam int V_W   = 38;
	localparam int NP_W  = 40;
	localparam int D_W   = 41;
	localparam int S_W   = 40;
	localparam int SLO_W = 24;
	localparam int SHI_W = S_W - SLO_W;
	localparam int LANES = 7;
	localparam logic signed [R_W-1:0] ONE_R = R_W'(32'sh4000_0000);

	// Configuration registers.
	logic        [31:0] gain_q;
	logic signed [31:0] t_q [3];
	logic signed [31:0] qw_q, qx_q, qy_q, qz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			t_q[0] <= '0;
			t_q[1] <= '0;
			t_q[2] <= '0;
			qw_q   <= QUAT_W_RESET;
			qx_q   <= '0;
			qy_q   <= '0;
			qz_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIN:    gain_q <= cfg_data;
				REG_TRANS_X: t_q[0] <= cfg_data;
				REG_TRANS_Y: t_q[1] <= cfg_data;
				REG_TRANS_Z: t_q[2] <= cfg_data;
				REG_QUAT_W:  qw_q   <= cfg_data;
				REG_QUAT_X:  qx_q   <= cfg_data;
				REG_QUAT_Y:  qy_q   <= cfg_data;
				REG_QUAT_Z:  qz_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline control: every stage advances together unless the output is held.
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	assign en          = !(v_s8 && result_stall);
	assign point_stall = !en;
	assign result_valid = v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= point_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Stage 1: doubled quaternion products and the combined scale.
	logic signed [63:0]   qp_prod [9];
	logic signed [PW-1:0] qp_rnd  [9];
	logic        [63:0]   gw_prod;
	logic signed [PW-1:0] s_rnd;

	assign qp_prod[0] = qx_q * qx_q;
	assign qp_prod[1] = qy_q * qy_q;
	assign qp_prod[2] = qz_q * qz_q;
	assign qp_prod[3] = qx_q * qy_q;
	assign qp_prod[4] = qx_q * qz_q;
	assign qp_prod[5] = qy_q * qz_q;
	assign qp_prod[6] = qw_q * qx_q;
	assign qp_prod[7] = qw_q * qy_q;
	assign qp_prod[8] = qw_q * qz_q;

	for (genvar k = 0; k < 9; k++) begin : g_qp
		assign qp_rnd[k] = rnd_sh(PW'(qp_prod[k]), 29);
	end

	assign gw_prod = gain_q * point_data.point_weight;
	assign s_rnd   = rnd_sh(PW'(gw_prod), 24);

	logic signed [QP_W-1:0] qp_s1 [9];
	logic        [S_W-1:0]  s_s1, s_s2, s_s3, s_s4, s_s5, s_s6;
	logic signed [31:0]     p_s1 [3], p_s2 [3], p_s3 [3], p_s4 [3];
	logic signed [31:0]     n_s1 [3], n_s2 [3], n_s3 [3], n_s4 [3], n_s5 [3];
	logic signed [31:0]     off_s1, off_s2, off_s3, off_s4, off_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++)
				qp_s1[k] <= qp_rnd[k][QP_W-1:0];
			s_s1   <= s_rnd[S_W-1:0];
			p_s1[0] <= point_data.point_x;
			p_s1[1] <= point_data.point_y;
			p_s1[2] <= point_data.point_z;
			n_s1[0] <= point_data.normal_x;
			n_s1[1] <= point_data.normal_y;
			n_s1[2] <= point_data.normal_z;
			off_s1  <= point_data.plane_offset;
		end
	end

	// Stage 2: rotation matrix.
	logic signed [R_W-1:0] r_s2 [3][3];

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2[0][0] <= ONE_R - (R_W'(qp_s1[1]) + R_W'(qp_s1[2]));
			r_s2[0][1] <= R_W'(qp_s1[3]) - R_W'(qp_s1[8]);
			r_s2[0][2] <= R_W'(qp_s1[4]) + R_W'(qp_s1[7]);
			r_s2[1][0] <= R_W'(qp_s1[3]) + R_W'(qp_s1[8]);
			r_s2[1][1] <= ONE_R - (R_W'(qp_s1[0]) + R_W'(qp_s1[2]));
			r_s2[1][2] <= R_W'(qp_s1[5]) - R_W'(qp_s1[6]);
			r_s2[2][0] <= R_W'(qp_s1[4]) - R_W'(qp_s1[7]);
			r_s2[2][1] <= R_W'(qp_s1[5]) + R_W'(qp_s1[6]);
			r_s2[2][2] <= ONE_R - (R_W'(qp_s1[0]) + R_W'(qp_s1[1]));
			s_s2   <= s_s1;
			p_s2   <= p_s1;
			n_s2   <= n_s1;
			off_s2 <= off_s1;
		end
	end

	// Stage 3: R*p terms of the world point and n*R terms of u = n^T R.
	logic signed [RP_W-1:0] rp_c [3][3];
	logic signed [RP_W-1:0] nr_c [3][3];

	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			logic signed [R_W+31:0] rp_prod, nr_prod;
			logic signed [PW-1:0]   rp_rnd, nr_rnd;
			assign rp_prod = r_s2[i][j] * p_s2[j];
			assign nr_prod = n_s2[i] * r_s2[i][j];
			assign rp_rnd  = rnd_sh(PW'(rp_prod), 30);
			assign nr_rnd  = rnd_sh(PW'(nr_prod), 30);
			assign rp_c[i][j] = rp_rnd[RP_W-1:0];
			assign nr_c[i][j] = nr_rnd[RP_W-1:0];
		end
	end

	logic signed [RP_W-1:0] rp_s3 [3][3];
	logic signed [RP_W-1:0] nr_s3 [3][3];

	always_ff @(posedge clk) begin
		if (en) begin
			rp_s3  <= rp_c;
			nr_s3  <= nr_c;
			s_s3   <= s_s2;
			p_s3   <= p_s2;
			n_s3   <= n_s2;
			off_s3 <= off_s2;
		end
	end

	// Stage 4: world point and u.
	logic signed [V_W-1:0] pw_s4 [3];
	logic signed [V_W-1:0] u_s4  [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pw_s4[i] <= V_W'(rp_s3[i][0]) + V_W'(rp_s3[i][1]) + V_W'(rp_s3[i][2])
					+ V_W'(t_q[i]);
				u_s4[i]  <= V_W'(nr_s3[0][i]) + V_W'(nr_s3[1][i]) + V_W'(nr_s3[2][i]);
			end
			s_s4   <= s_s3;
			p_s4   <= p_s3;
			n_s4   <= n_s3;
			off_s4 <= off_s3;
		end
	end

	// Stage 5: plane distance terms and cross product terms.
	logic signed [NP_W-1:0] np_c  [3];
	logic signed [NP_W-1:0] cpa_c [3];
	logic signed [NP_W-1:0] cpb_c [3];

	for (genvar k = 0; k < 3; k++) begin : g_cross
		localparam int A = (k + 1) % 3;
		localparam int B = (k + 2) % 3;
		logic signed [V_W+31:0] np_prod, cpa_prod, cpb_prod;
		logic signed [PW-1:0]   np_rnd, cpa_rnd, cpb_rnd;
		assign np_prod  = n_s4[k] * pw_s4[k];
		assign cpa_prod = u_s4[A] * p_s4[B];
		assign cpb_prod = u_s4[B] * p_s4[A];
		assign np_rnd   = rnd_sh(PW'(np_prod), 30);
		assign cpa_rnd  = rnd_sh(PW'(cpa_prod), 30);
		assign cpb_rnd  = rnd_sh(PW'(cpb_prod), 30);
		assign np_c[k]  = np_rnd[NP_W-1:0];
		assign cpa_c[k] = cpa_rnd[NP_W-1:0];
		assign cpb_c[k] = cpb_rnd[NP_W-1:0];
	end

	logic signed [NP_W-1:0] np_s5 [3], cpa_s5 [3], cpb_s5 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			np_s5  <= np_c;
			cpa_s5 <= cpa_c;
			cpb_s5 <= cpb_c;
			s_s5   <= s_s4;
			n_s5   <= n_s4;
			off_s5 <= off_s4;
		end
	end

	// Stage 6: lane 0 is the distance, lanes 1-3 the normal, lanes 4-6 the cross product.
	logic signed [D_W-1:0] lane_s6 [LANES];

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s6[0] <= D_W'(np_s5[0]) + D_W'(np_s5[1]) + D_W'(np_s5[2]) + D_W'(off_s5);
			for (int k = 0; k < 3; k++) begin
				lane_s6[1 + k] <= D_W'(n_s5[k]);
				lane_s6[4 + k] <= D_W'(cpa_s5[k]) - D_W'(cpb_s5[k]);
			end
			s_s6 <= s_s5;
		end
	end

	// Stage 7: each lane times the scale, split into low and high parts of the scale.
	localparam int LO_W = D_W + SLO_W + 1;
	localparam int HI_W = D_W + SHI_W + 1;

	logic signed [SLO_W:0] s_lo;
	logic signed [SHI_W:0] s_hi;
	logic signed [LO_W-1:0] lo_c [LANES];
	logic signed [HI_W-1:0] hi_c [LANES];

	assign s_lo = $signed({1'b0, s_s6[SLO_W-1:0]});
	assign s_hi = $signed({1'b0, s_s6[S_W-1:SLO_W]});

	for (genvar k = 0; k < LANES; k++) begin : g_scale
		assign lo_c[k] = lane_s6[k] * s_lo;
		assign hi_c[k] = lane_s6[k] * s_hi;
	end

	logic signed [LO_W-1:0] lo_s7 [LANES];
	logic signed [HI_W-1:0] hi_s7 [LANES];

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s7 <= lo_c;
			hi_s7 <= hi_c;
		end
	end

	// Stage 8: recombine, round, saturate; this register drives the result channel.
	logic signed [PW-1:0] full_c [LANES];
	logic signed [PW-1:0] r30_c  [LANES];
	logic signed [PW-1:0] r44_c  [LANES];

	for (genvar k = 0; k < LANES; k++) begin : g_final
		assign full_c[k] = (PW'(hi_s7[k]) <<< SLO_W) + PW'(lo_s7[k]);
		assign r30_c[k]  = rnd_sh(full_c[k], 30);
		assign r44_c[k]  = rnd_sh(full_c[k], 44);
	end

	result_t out_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			out_s8.residual    <= sat32(r30_c[0]);
			out_s8.jac_trans_x <= sat32(r44_c[1]);
			out_s8.jac_trans_y <= sat32(r44_c[2]);
			out_s8.jac_trans_z <= sat32(r44_c[3]);
			out_s8.jac_rot_x   <= sat32(-r30_c[4]);
			out_s8.jac_rot_y   <= sat32(-r30_c[5]);
			out_s8.jac_rot_z   <= sat32(-r30_c[6]);
		end
	end

	assign result_data = out_s8;

`include "point_plane_residual_jacobian_assert.svh"

	`PPRJ_ASSERT_SAME(a_stall_cause, point_stall, result_valid && result_stall,
		"input stalled without a held result")
	`PPRJ_ASSERT_NEXT(a_enter, point_valid && !point_stall, v_s1,
		"accepted point did not enter the first stage")
	`PPRJ_ASSERT_NEXT(a_drain, v_s7 && !point_stall, result_valid,
		"last stage item did not reach the output register")

endmodule

// ----- sim/tb_point_plane_residual_jacobian.sv -----
// Self-checking testbench for the point-to-plane residual and Jacobian block.
module tb_point_plane_residual_jacobian
	import pprj_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint WIDE_CAP = 64'h0FFF_FFFF_FFFF_FFFF;
	localparam int DRAIN_CYCLES = 20;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;
	logic point_valid, point_stall;
	point_t point_data;
	logic result_valid, result_stall;
	result_t result_data;

	int send_idle_pct, stall_pct;
	int fail_count;
	longint cycle_count;

	point_plane_residual_jacobian dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.point_valid(point_valid), .point_stall(point_stall), .point_data(point_data),
		.result_valid(result_valid), .result_stall(result_stall), .result_data(result_data)
	);

	// Predicts the residual and Jacobians for each point and holds them in order.
	class residual_scoreboard;
		logic [31:0] pose_regs [8];
		result_t expected_q [$];

		function new();
			pose_regs[REG_GAIN] = GAIN_RESET;
			pose_regs[REG_TRANS_X] = '0;
			pose_regs[REG_TRANS_Y] = '0;
			pose_regs[REG_TRANS_Z] = '0;
			pose_regs[REG_QUAT_W] = QUAT_W_RESET;
			pose_regs[REG_QUAT_X] = '0;
			pose_regs[REG_QUAT_Y] = '0;
			pose_regs[REG_QUAT_Z] = '0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [31:0] val);
			pose_regs[idx] = val;
		endfunction

		function longint clip(longint v);
			if (v > WIDE_CAP) return WIDE_CAP;
			if (v < -WIDE_CAP) return -WIDE_CAP;
			return v;
		endfunction

		// Exact product, scaled down by 2^sh with ties away from zero, clamped.
		function longint mul_round(longint a, longint b, int sh);
			logic [127:0] mag;
			logic [127:0] q;
			bit neg;
			neg = (a < 0) != (b < 0);
			mag = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
			q = (mag + (128'd1 << (sh - 1))) >> sh;
			if (q > 128'(WIDE_CAP)) q = 128'(WIDE_CAP);
			return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
		endfunction

		function logic [31:0] to_out(longint v);
			if (v > 64'sd2147483647) v = 64'sd2147483647;
			if (v < -64'sd2147483648) v = -64'sd2147483648;
			return v[31:0];
		endfunction

		function void note_point(point_t pt);
			longint one, qw, qx, qy, qz, xx, yy, zz, xy, xz, yz, wx, wy, wz, plane_d, scale;
			longint tr [3];
			longint pnt [3];
			longint nrm [3];
			longint wpt [3];
			longint un [3];
			longint crs [3];
			longint rot [3][3];
			result_t r;
			one = 64'sd1 << 30;
			qw = longint'($signed(pose_regs[REG_QUAT_W]));
			qx = longint'($signed(pose_regs[REG_QUAT_X]));
			qy = longint'($signed(pose_regs[REG_QUAT_Y]));
			qz = longint'($signed(pose_regs[REG_QUAT_Z]));
			tr[0] = longint'($signed(pose_regs[REG_TRANS_X]));
			tr[1] = longint'($signed(pose_regs[REG_TRANS_Y]));
			tr[2] = longint'($signed(pose_regs[REG_TRANS_Z]));
			pnt[0] = pt.point_x; pnt[1] = pt.point_y; pnt[2] = pt.point_z;
			nrm[0] = pt.normal_x; nrm[1] = pt.normal_y; nrm[2] = pt.normal_z;
			xx = mul_round(qx, qx, 29); yy = mul_round(qy, qy, 29);
			zz = mul_round(qz, qz, 29); xy = mul_round(qx, qy, 29);
			xz = mul_round(qx, qz, 29); yz = mul_round(qy, qz, 29);
			wx = mul_round(qw, qx, 29); wy = mul_round(qw, qy, 29);
			wz = mul_round(qw, qz, 29);
			rot[0][0] = clip(one - (yy + zz));
			rot[0][1] = clip(xy - wz);
			rot[0][2] = clip(xz + wy);
			rot[1][0] = clip(xy + wz);
			rot[1][1] = clip(one - (xx + zz));
			rot[1][2] = clip(yz - wx);
			rot[2][0] = clip(xz - wy);
			rot[2][1] = clip(yz + wx);
			rot[2][2] = clip(one - (xx + yy));
			for (int i = 0; i < 3; i++)
				wpt[i] = clip(mul_round(rot[i][0], pnt[0], 30) + mul_round(rot[i][1], pnt[1], 30)
					+ mul_round(rot[i][2], pnt[2], 30) + tr[i]);
			plane_d = clip(mul_round(nrm[0], wpt[0], 30) + mul_round(nrm[1], wpt[1], 30)
				+ mul_round(nrm[2], wpt[2], 30) + longint'(pt.plane_offset));
			scale = mul_round(longint'({32'd0, pose_regs[REG_GAIN]}),
				longint'({32'd0, pt.point_weight}), 24);
			for (int i = 0; i < 3; i++)
				un[i] = clip(mul_round(nrm[0], rot[0][i], 30) + mul_round(nrm[1], rot[1][i], 30)
					+ mul_round(nrm[2], rot[2][i], 30));
			crs[0] = clip(mul_round(un[1], pnt[2], 30) - mul_round(un[2], pnt[1], 30));
			crs[1] = clip(mul_round(un[2], pnt[0], 30) - mul_round(un[0], pnt[2], 30));
			crs[2] = clip(mul_round(un[0], pnt[1], 30) - mul_round(un[1], pnt[0], 30));
			r.residual = to_out(mul_round(scale, plane_d, 30));
			r.jac_trans_x = to_out(mul_round(scale, nrm[0], 44));
			r.jac_trans_y = to_out(mul_round(scale, nrm[1], 44));
			r.jac_trans_z = to_out(mul_round(scale, nrm[2], 44));
			r.jac_rot_x = to_out(-mul_round(scale, crs[0], 30));
			r.jac_rot_y = to_out(-mul_round(scale, crs[1], 30));
			r.jac_rot_z = to_out(-mul_round(scale, crs[2], 30));
			expected_q.push_back(r);
		endfunction

		function int check_result(result_t got);
			result_t exp_r;
			int errs;
			errs = 0;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				return 1;
			end
			exp_r = expected_q.pop_front();
			if (got.residual !== exp_r.residual) begin
				$display("%0t: residual expected %h actual %h", $time, exp_r.residual, got.residual);
				errs++;
			end
			if (got.jac_trans_x !== exp_r.jac_trans_x) begin
				$display("%0t: jac_trans_x expected %h actual %h", $time,
					exp_r.jac_trans_x, got.jac_trans_x);
				errs++;
			end
			if (got.jac_trans_y !== exp_r.jac_trans_y) begin
				$display("%0t: jac_trans_y expected %h actual %h", $time,
					exp_r.jac_trans_y, got.jac_trans_y);
				errs++;
			end
			if (got.jac_trans_z !== exp_r.jac_trans_z) begin
				$display("%0t: jac_trans_z expected %h actual %h", $time,
					exp_r.jac_trans_z, got.jac_trans_z);
				errs++;
			end
			if (got.jac_rot_x !== exp_r.jac_rot_x) begin
				$display("%0t: jac_rot_x expected %h actual %h", $time,
					exp_r.jac_rot_x, got.jac_rot_x);
				errs++;
			end
			if (got.jac_rot_y !== exp_r.jac_rot_y) begin
				$display("%0t: jac_rot_y expected %h actual %h", $time,
					exp_r.jac_rot_y, got.jac_rot_y);
				errs++;
			end
			if (got.jac_rot_z !== exp_r.jac_rot_z) begin
				$display("%0t: jac_rot_z expected %h actual %h", $time,
					exp_r.jac_rot_z, got.jac_rot_z);
				errs++;
			end
			return errs > 0 ? 1 : 0;
		endfunction
	endclass

	residual_scoreboard plane_sb;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result side: random stall and checking of every transfer.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (result_valid && !result_stall)
				fail_count <= fail_count + plane_sb.check_result(result_data);
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("point_plane_residual_jacobian regression: fail");
			$finish;
		end
	end

	// Each write raises the enable and then leaves it low for the following cycle.
	task automatic write_pose(cfg_reg_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		plane_sb.write_reg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Holds the point until the block takes it; the transfer is noted at that edge.
	task automatic send_point(point_t pt);
		while ($urandom_range(99) < send_idle_pct) begin
			point_valid <= 1'b0;
			@(posedge clk);
		end
		point_valid <= 1'b1;
		point_data <= pt;
		@(posedge clk);
		while (point_stall) @(posedge clk);
		plane_sb.note_point(pt);
	endtask

	task automatic wait_idle();
		point_valid <= 1'b0;
		@(posedge clk);
		while (plane_sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_q30();
		case ($urandom_range(5))
			0: return 32'h4000_0000;
			1: return 32'hC000_0000;
			2: return 32'(int'($urandom_range(2147483647)) - 1073741824) >>> 0;
			default: return 32'($signed($urandom) >>> 1);
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom) >>> 8);
			default: return 32'($signed($urandom) >>> 12);
		endcase
	endfunction

	function automatic point_t rand_point();
		point_t pt;
		pt.point_x = rand_coord();
		pt.point_y = rand_coord();
		pt.point_z = rand_coord();
		pt.normal_x = rand_q30();
		pt.normal_y = rand_q30();
		pt.normal_z = rand_q30();
		pt.plane_offset = rand_coord();
		pt.point_weight = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h4000_0000);
		return pt;
	endfunction

	task automatic random_pose();
		write_pose(REG_GAIN, ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0400_0000));
		write_pose(REG_TRANS_X, rand_coord());
		write_pose(REG_TRANS_Y, rand_coord());
		write_pose(REG_TRANS_Z, rand_coord());
		write_pose(REG_QUAT_W, rand_q30());
		write_pose(REG_QUAT_X, rand_q30());
		write_pose(REG_QUAT_Y, rand_q30());
		write_pose(REG_QUAT_Z, rand_q30());
	endtask

	initial begin
		point_t pt;
		plane_sb = new();
		fail_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_GAIN;
		cfg_data = '0;
		point_valid = 1'b0;
		point_data = '0;
		result_stall = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed points under the reset pose: extremes, ties and saturation.
		pt = '0;
		send_point(pt);
		pt = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h4000_0000, 32'h4000_0000,
			32'h4000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
		send_point(pt);
		pt = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hC000_0000, 32'hC000_0000,
			32'hC000_0000, 32'h8000_0000, 32'hFFFF_FFFF};
		send_point(pt);
		pt = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h4000_0000, 32'h0,
			32'h0, 32'h0, 32'h4000_0000};
		send_point(pt);
		pt = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF,
			32'h2000_0000, 32'h0000_0001, 32'h0000_0001};
		send_point(pt);
		pt = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		send_point(pt);
		wait_idle();

		// Extreme pose: maximum gain, non-unit quaternion and far translation.
		write_pose(REG_GAIN, 32'hFFFF_FFFF);
		write_pose(REG_TRANS_X, 32'h7FFF_FFFF);
		write_pose(REG_TRANS_Y, 32'h8000_0000);
		write_pose(REG_TRANS_Z, 32'h0001_0000);
		write_pose(REG_QUAT_W, 32'hC000_0000);
		write_pose(REG_QUAT_X, 32'h4000_0000);
		write_pose(REG_QUAT_Y, 32'h8000_0000);
		write_pose(REG_QUAT_Z, 32'h7FFF_FFFF);
		repeat (6) send_point(rand_point());
		wait_idle();

		// Zero gain and a quarter turn about z.
		write_pose(REG_GAIN, 32'h0);
		write_pose(REG_QUAT_W, 32'h2D41_3CCD);
		write_pose(REG_QUAT_Z, 32'h2D41_3CCD);
		write_pose(REG_QUAT_X, 32'h0);
		write_pose(REG_QUAT_Y, 32'h0);
		repeat (3) send_point(rand_point());
		wait_idle();
		write_pose(REG_GAIN, GAIN_RESET);
		repeat (6) send_point(rand_point());

		// Random phases: each gets a fresh pose and one of four idle and stall patterns.
		for (int phase = 0; phase < 12; phase++) begin
			wait_idle();
			random_pose();
			case (phase % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 82; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 82; end
				default: begin send_idle_pct = 8; stall_pct = 8; end
			endcase
			for (int k = 0; k < 100; k++) begin
				send_point(rand_point());
				// Midway through each phase the sender waits for the pipeline to empty.
				if (k == 50) begin
					point_valid <= 1'b0;
					@(posedge clk);
					while (plane_sb.expected_q.size() != 0) @(posedge clk);
				end
			end
		end

		wait_idle();
		if (fail_count == 0)
			$display("point_plane_residual_jacobian regression: pass");
		else
			$display("point_plane_residual_jacobian regression: fail");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/pprj_pkg.sv
sv/point_plane_residual_jacobian.sv
sim/tb_point_plane_residual_jacobian.sv
